>>> rtl/pkd_pkg.sv
package pkd_pkg;

    localparam int unsigned KEY_LEN      = 16;
    localparam int unsigned ALPHA_SIZE   = 24;
    localparam logic [31:0] UNMASK_CONST = 32'h13AC9741;
    localparam logic [7:0]  CHECK_INIT   = 8'd3;
    localparam logic [3:0]  LAST_POS     = 4'd15;

    typedef logic [15:0][3:0] pkd_nibs_t;

    typedef struct packed {
        pkd_nibs_t nibs;
        logic      ok;
        logic      bad;
    } pkd_job_t;

    typedef struct packed {
        logic       ok;
        logic [4:0] sym;
    } pkd_sym_t;

    function automatic pkd_sym_t pkd_symbol(input logic [7:0] c);
        logic [7:0] u;
        pkd_sym_t   r;
        u = (c >= 8'h60 && c <= 8'h7F) ? c - 8'h20 : c;
        r.ok = 1'b1;
        unique case (u)
            8'h32:   r.sym = 5'd0;
            8'h34:   r.sym = 5'd1;
            8'h36:   r.sym = 5'd2;
            8'h37:   r.sym = 5'd3;
            8'h38:   r.sym = 5'd4;
            8'h39:   r.sym = 5'd5;
            8'h42:   r.sym = 5'd6;
            8'h43:   r.sym = 5'd7;
            8'h44:   r.sym = 5'd8;
            8'h45:   r.sym = 5'd9;
            8'h46:   r.sym = 5'd10;
            8'h47:   r.sym = 5'd11;
            8'h48:   r.sym = 5'd12;
            8'h4A:   r.sym = 5'd13;
            8'h4B:   r.sym = 5'd14;
            8'h4D:   r.sym = 5'd15;
            8'h4E:   r.sym = 5'd16;
            8'h50:   r.sym = 5'd17;
            8'h52:   r.sym = 5'd18;
            8'h54:   r.sym = 5'd19;
            8'h56:   r.sym = 5'd20;
            8'h57:   r.sym = 5'd21;
            8'h58:   r.sym = 5'd22;
            8'h5A:   r.sym = 5'd23;
            default: begin
                r.ok  = 1'b0;
                r.sym = 5'd0;
            end
        endcase
        return r;
    endfunction

    function automatic logic [7:0] pkd_check_step(input logic [7:0] v, input logic [3:0] d);
        return v + ({4'b0000, d} ^ {v[6:0], 1'b0});
    endfunction

    // source position of each nibble after the swap sequence
    function automatic logic [3:0] pkd_perm_src(input int unsigned k);
        logic [3:0]  idx [KEY_LEN];
        logic [3:0]  t;
        int unsigned j;
        for (int i = 0; i < KEY_LEN; i++) begin
            idx[i] = 4'(i);
        end
        for (int i = KEY_LEN - 1; i >= 0; i--) begin
            j      = (i + 7) % KEY_LEN;
            t      = idx[i];
            idx[i] = idx[j];
            idx[j] = t;
        end
        return idx[k];
    endfunction

endpackage

>>> rtl/pkd_front.sv
module pkd_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // key_char
    output logic              push,
    output pkd_pkg::pkd_job_t push_job,
    input  logic              q_full
);
    import pkd_pkg::*;

    logic [3:0]  count_reg;
    logic [4:0]  first_reg;
    pkd_nibs_t   nib_reg;
    logic [7:0]  csum_reg;
    logic [7:0]  check_reg;
    logic        bad_reg;

    pkd_sym_t    sym;
    logic [9:0]  pair_n;
    logic        odd;
    logic        accept;
    pkd_nibs_t   nib_next;
    logic [7:0]  csum_next;
    logic [7:0]  check_next;
    logic        bad_next;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign odd      = count_reg[0];

    always_comb begin
        sym        = pkd_symbol(s_tdata);
        pair_n     = 10'(first_reg) * 10'd24 + 10'(sym.sym);
        nib_next   = nib_reg;
        csum_next  = csum_reg;
        check_next = check_reg;
        bad_next   = bad_reg | !sym.ok;
        if (odd) begin
            nib_next[{count_reg[3:1], 1'b0}] = pair_n[7:4];
            nib_next[{count_reg[3:1], 1'b1}] = pair_n[3:0];
            if (pair_n[9:8] != 2'b00) begin
                csum_next = csum_reg | (8'd1 << count_reg[3:1]);
            end
            check_next = pkd_check_step(pkd_check_step(check_reg, pair_n[7:4]), pair_n[3:0]);
        end
    end

    assign push          = accept && (count_reg == LAST_POS);
    assign push_job.nibs = nib_next;
    assign push_job.ok   = (check_next == csum_next) && !bad_next;
    assign push_job.bad  = bad_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 4'd0;
            first_reg <= 5'd0;
            csum_reg  <= 8'd0;
            check_reg <= CHECK_INIT;
            bad_reg   <= 1'b0;
        end else if (accept) begin
            count_reg <= count_reg + 4'd1;
            if (!odd) begin
                first_reg <= sym.sym;
            end
            if (count_reg == LAST_POS) begin
                first_reg <= 5'd0;
                csum_reg  <= 8'd0;
                check_reg <= CHECK_INIT;
                bad_reg   <= 1'b0;
            end else begin
                csum_reg  <= csum_next;
                check_reg <= check_next;
                bad_reg   <= bad_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            nib_reg <= nib_next;
        end
    end

endmodule

>>> rtl/pkd_queue.sv
module pkd_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  pkd_pkg::pkd_job_t push_job,
    output logic              q_full,
    input  logic              pop,
    output logic              q_valid,
    output pkd_pkg::pkd_job_t pop_job
);
    import pkd_pkg::*;

    pkd_job_t   mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    assign q_full  = fill_reg == 2'd2;
    assign q_valid = fill_reg != 2'd0;
    assign pop_job = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push && !q_full) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop && q_valid) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'((push && !q_full) ? 1 : 0) - 2'((pop && q_valid) ? 1 : 0);
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !q_full) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> rtl/pkd_back.sv
module pkd_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  pkd_pkg::pkd_job_t pop_job,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [71:0]       m_tdata    // key_ok, bad_char, product_value, public_code,
                                         // private_value, zero fill
);
    import pkd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } back_state_t;

    back_state_t state_reg;
    logic [3:0]  idx_reg;
    logic [31:0] slices_reg;
    pkd_nibs_t   work_reg;
    logic        ok_reg;
    logic        bad_reg;

    pkd_nibs_t   loaded;
    logic [3:0]  d;
    logic [3:0]  d_next;
    logic        d_low;
    logic [63:0] flat;

    for (genvar k = 0; k < KEY_LEN; k++) begin : g_perm
        assign loaded[k]           = pop_job.nibs[pkd_perm_src(k)];
        assign flat[4*(15-k) +: 4] = work_reg[k];
    end

    assign pop   = (state_reg == S_IDLE) && q_valid;
    assign d     = work_reg[idx_reg];
    assign d_low = d < 4'd8;

    always_comb begin
        if (d_low) begin
            d_next = d ^ {1'b0, slices_reg[2:0]};
        end else if (d < 4'd10) begin
            d_next = d ^ {3'b000, idx_reg[0]};
        end else begin
            d_next = d;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        state_reg <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (idx_reg == 4'd0) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (m_tready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            work_reg   <= loaded;
            slices_reg <= UNMASK_CONST;
            idx_reg    <= LAST_POS;
            ok_reg     <= pop_job.ok;
            bad_reg    <= pop_job.bad;
        end else if (state_reg == S_RUN) begin
            work_reg[idx_reg] <= d_next;
            idx_reg           <= idx_reg - 4'd1;
            if (d_low) begin
                slices_reg <= slices_reg >> 3;
            end
        end
    end

    assign m_tvalid = state_reg == S_DONE;
    assign m_tdata  = {6'b000000,
                       ok_reg ? {flat[31:0], flat[55:32], flat[63:56]} : 64'd0,
                       bad_reg, ok_reg};

    a_run_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RUN && idx_reg == 4'd0) |=> state_reg == S_DONE)
        else $error("scan did not finish after last digit");

    a_run_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RUN) |=> (state_reg == S_DONE || idx_reg == $past(idx_reg) - 4'd1))
        else $error("digit index skipped");

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[65:2] == 64'd0))
        else $error("rejected key carries nonzero values");

endmodule

>>> rtl/product_key_decoder.sv
// Decodes a sixteen-character product key fed one character per transaction on
// the slave side, and after the sixteenth character emits one result transaction
// with the ok and bad-character flags and the product, public and private values
// (values read zero when the key is rejected). Characters are accepted one per
// cycle while the two-key queue is not full; each completed key then passes
// through the unmasking unit (one load, sixteen single-digit steps, then an output
// state held until the result is taken), and the queue lets loading run ahead
// of the unmasking unit.
module product_key_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // key_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // key_ok, bad_char, product_value, public_code,
                                   // private_value, zero fill
);
    import pkd_pkg::*;

    logic     push;
    logic     q_full;
    logic     q_valid;
    logic     pop;
    pkd_job_t push_job;
    pkd_job_t pop_job;

    pkd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .push     (push),
        .push_job (push_job),
        .q_full   (q_full)
    );

    pkd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .q_full   (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .pop_job  (pop_job)
    );

    pkd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .pop_job  (pop_job),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> tb/product_key_decoder_test.sv
`timescale 1ns / 1ps

module product_key_decoder_test;
    import pkd_pkg::*;

    typedef struct packed {
        logic [31:0] private_value;
        logic [23:0] public_code;
        logic [7:0]  product_value;
        logic        bad_char;
        logic        key_ok;
    } key_result_t;

    typedef logic [KEY_LEN-1:0][7:0] key_chars_t;

    localparam logic [8*24-1:0] KEY_ALPHABET = "246789BCDEFGHJKMNPRTVWXZ";

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;

    product_key_decoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    logic [3:0]  dec_pos;
    logic [4:0]  dec_first;
    pkd_nibs_t   dec_nibs;
    logic [7:0]  dec_csum;
    logic [7:0]  dec_check;
    logic        dec_bad;
    key_result_t pending_keys [$];
    int          errors     = 0;
    int          burst_left = 0;
    int          ready_mode = 0;
    int          mode_cycles = 0;

    function automatic logic [7:0] alphabet_char(input int k, input bit lower);
        logic [7:0] c;
        c = KEY_ALPHABET[8*(ALPHA_SIZE-1-k) +: 8];
        if (lower && c >= 8'h41) begin
            c = c + 8'h20;
        end
        return c;
    endfunction

    function automatic int symbol_index(input logic [7:0] c);
        logic [7:0] u;
        u = c;
        if (c >= 8'h60 && c <= 8'h7F) begin
            u = c - 8'h20;
        end
        for (int k = 0; k < ALPHA_SIZE; k++) begin
            if (alphabet_char(k, 1'b0) == u) begin
                return k;
            end
        end
        return -1;
    endfunction

    function automatic logic [7:0] mix_check(input logic [7:0] v, input logic [3:0] d);
        logic [7:0] twice;
        twice = v << 1;
        return v + (twice ^ 8'(d));
    endfunction

    function automatic key_result_t unmask_key(input pkd_nibs_t nibs, input logic ok,
                                               input logic bad);
        pkd_nibs_t   w;
        logic [3:0]  t;
        logic [31:0] slices;
        key_result_t r;
        int          j;
        w = nibs;
        for (int i = KEY_LEN - 1; i >= 0; i--) begin
            j    = (i + 7) % KEY_LEN;
            t    = w[i];
            w[i] = w[j];
            w[j] = t;
        end
        slices = UNMASK_CONST;
        for (int i = KEY_LEN - 1; i >= 0; i--) begin
            if (w[i] < 4'd8) begin
                w[i]   = w[i] ^ {1'b0, slices[2:0]};
                slices = slices >> 3;
            end else if (w[i] < 4'd10) begin
                w[i] = w[i] ^ 4'(i & 1);
            end
        end
        r          = '0;
        r.key_ok   = ok;
        r.bad_char = bad;
        if (ok) begin
            r.product_value = {w[0], w[1]};
            r.public_code   = {w[2], w[3], w[4], w[5], w[6], w[7]};
            r.private_value = {w[8], w[9], w[10], w[11], w[12], w[13], w[14], w[15]};
        end
        return r;
    endfunction

    function automatic void clear_decoder();
        dec_pos   = '0;
        dec_first = '0;
        dec_csum  = '0;
        dec_check = CHECK_INIT;
        dec_bad   = 1'b0;
    endfunction

    // advance the decoder state by one accepted character
    function automatic void decode_char(input logic [7:0] c);
        int         s;
        logic [9:0] n;
        logic       ok;
        s = symbol_index(c);
        if (s < 0) begin
            dec_bad = 1'b1;
            s       = 0;
        end
        if (!dec_pos[0]) begin
            dec_first = 5'(s);
        end else begin
            n = 10'(24 * int'(dec_first) + s);
            if (n >= 10'd256) begin
                n                      = n - 10'd256;
                dec_csum[dec_pos[3:1]] = 1'b1;
            end
            dec_nibs[dec_pos - 4'd1] = n[7:4];
            dec_nibs[dec_pos]        = n[3:0];
            dec_check = mix_check(mix_check(dec_check, n[7:4]), n[3:0]);
        end
        if (dec_pos == LAST_POS) begin
            ok = (dec_check == dec_csum) && !dec_bad;
            pending_keys.push_back(unmask_key(dec_nibs, ok, dec_bad));
            clear_decoder();
        end else begin
            dec_pos = dec_pos + 4'd1;
        end
    endfunction

    // random key whose last pair is chosen so that the checksum holds
    task automatic make_valid_key(output key_chars_t key);
        int         syms [KEY_LEN];
        logic [7:0] v;
        logic [7:0] csum;
        int         n;
        int         idx;
        int         start;
        bit         found;
        found = 1'b0;
        while (!found) begin
            v    = CHECK_INIT;
            csum = '0;
            for (int p = 0; p < 7; p++) begin
                syms[2*p]     = $urandom_range(0, ALPHA_SIZE - 1);
                syms[2*p + 1] = $urandom_range(0, ALPHA_SIZE - 1);
                n = 24 * syms[2*p] + syms[2*p + 1];
                if (n >= 256) begin
                    n       = n - 256;
                    csum[p] = 1'b1;
                end
                v = mix_check(mix_check(v, 4'(n >> 4)), 4'(n));
            end
            start = $urandom_range(0, 575);
            for (int k = 0; k < 576 && !found; k++) begin
                idx     = (start + k) % 576;
                n       = (idx >= 256) ? idx - 256 : idx;
                csum[7] = (idx >= 256);
                if (mix_check(mix_check(v, 4'(n >> 4)), 4'(n)) == csum) begin
                    found    = 1'b1;
                    syms[14] = idx / 24;
                    syms[15] = idx % 24;
                end
            end
        end
        for (int i = 0; i < KEY_LEN; i++) begin
            key[i] = alphabet_char(syms[i], 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic send_char(input logic [7:0] c);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 96)
                                                     : $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        decode_char(c);
    endtask

    task automatic send_key(input key_chars_t key);
        for (int i = 0; i < KEY_LEN; i++) begin
            send_char(key[i]);
        end
    endtask

    // hold the input until every pending result has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (pending_keys.size() != 0);
    endtask

    task automatic test_directed();
        key_chars_t key;
        make_valid_key(key);
        send_key(key);
        make_valid_key(key);
        key[0]  = 8'h00;
        key[3]  = 8'hFF;
        key[5]  = 8'h7F;
        key[8]  = 8'h80;
        key[10] = 8'h60;
        key[12] = "a";
        key[13] = "Z";
        key[14] = "z";
        key[15] = "2";
        send_key(key);
    endtask

    task automatic test_random_keys(input int num_keys);
        key_chars_t key;
        int         kind;
        for (int k = 0; k < num_keys; k++) begin
            kind = $urandom_range(0, 9);
            make_valid_key(key);
            if (kind == 7) begin
                key[$urandom_range(0, KEY_LEN - 1)] =
                    ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                    : alphabet_char($urandom_range(0, ALPHA_SIZE - 1),
                                    1'($urandom_range(0, 1)));
            end else if (kind > 7) begin
                for (int i = 0; i < KEY_LEN; i++) begin
                    key[i] = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
                             : alphabet_char($urandom_range(0, ALPHA_SIZE - 1),
                                             1'($urandom_range(0, 1)));
                end
            end
            send_key(key);
        end
    endtask

    task automatic test_drain_pause();
        key_chars_t key;
        for (int k = 0; k < 3; k++) begin
            make_valid_key(key);
            send_key(key);
        end
        drain_results();
        for (int k = 0; k < 2; k++) begin
            make_valid_key(key);
            send_key(key);
        end
        drain_results();
    endtask

    task automatic test_back_to_back(input int num_keys);
        key_chars_t key;
        burst_left = KEY_LEN * num_keys + 1;
        for (int k = 0; k < num_keys; k++) begin
            make_valid_key(key);
            send_key(key);
        end
    endtask

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        if (mode_cycles == 0) begin
            ready_mode  = $urandom_range(0, 3);
            mode_cycles = $urandom_range(50, 400);
        end else begin
            mode_cycles--;
        end
        case (ready_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
            2: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
                m_tready <= ((mode_cycles % 16) < 3);
            end
        endcase
    end

    always @(posedge aclk) begin
        key_result_t got;
        key_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[65:0];
            if (pending_keys.size() == 0) begin
                errors++;
                $display("%0t: unexpected result expected none actual %0h", $time, got);
            end else begin
                want = pending_keys.pop_front();
                check_field("key_ok", want.key_ok, got.key_ok);
                check_field("bad_char", want.bad_char, got.bad_char);
                check_field("product_value", want.product_value, got.product_value);
                check_field("public_code", want.public_code, got.public_code);
                check_field("private_value", want.private_value, got.private_value);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        int wait_cycles;
        clear_decoder();
        dec_nibs = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_keys(60);
        test_drain_pause();
        test_back_to_back(15);
        s_tvalid <= 1'b0;
        wait_cycles = 0;
        while (pending_keys.size() != 0 && wait_cycles < 20000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (40) @(posedge aclk);
        if (pending_keys.size() != 0) begin
            errors += pending_keys.size();
            $display("%0t: missing results expected %0d actual 0", $time, pending_keys.size());
        end
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
